>>> sv/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on clk with arst_n as the disable
`define PS2MQ_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// check with an explicit clock and active-low reset
`define PS2MQ_ASSERT_CLK(label, clk_i, rst_n_i, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) \
		else $error("assertion failed");

`else

`define PS2MQ_ASSERT(label, prop)
`define PS2MQ_ASSERT_CLK(label, clk_i, rst_n_i, prop)

`endif

`endif

>>> sv/ps2mq_pkg.sv
`default_nettype none

package ps2mq_pkg;

	localparam int SLOT_COUNT  = 6;
	localparam int QUEUE_DEPTH = 64;

	localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int MEM_DEPTH = SLOT_COUNT * QUEUE_DEPTH;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam int BTN_W = 3;
	localparam int EV_W  = BTN_W + 16;

	// controller status and packet bits
	localparam int STATUS_FULL_BIT = 0;
	localparam int STATUS_AUX_BIT  = 5;
	localparam int SYNC_BIT        = 3;

	typedef struct packed {
		logic              valid;
		logic [BTN_W-1:0]  buttons;
		logic signed [7:0] dx;
		logic signed [7:0] dy;
	} ev_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] s,
		input logic [PTR_W-1:0] p);
		return ADDR_W'(s) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
	endfunction

endpackage

`default_nettype wire

>>> sv/ps2mq_assembler.sv
`default_nettype none

module ps2mq_assembler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  status_byte,
	input  wire logic [7:0]  data_byte,
	output ps2mq_pkg::ev_t   ev
);

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;

	logic [1:0] pos_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       aux_ok;

	assign aux_ok = status_byte[ps2mq_pkg::STATUS_FULL_BIT]
		& status_byte[ps2mq_pkg::STATUS_AUX_BIT];

	// packet completes on the third byte
	always_comb begin
		ev.valid   = take && aux_ok && (pos_q != POS_FIRST) && (pos_q != POS_SECOND);
		ev.buttons = first_q[ps2mq_pkg::BTN_W-1:0];
		ev.dx      = second_q;
		ev.dy      = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_FIRST;
			first_q  <= '0;
			second_q <= '0;
		end else if (take && aux_ok) begin
			case (pos_q)
				POS_FIRST: begin
					// resync: a first byte needs the always-one bit
					if (data_byte[ps2mq_pkg::SYNC_BIT]) begin
						first_q <= data_byte;
						pos_q   <= POS_SECOND;
					end
				end
				POS_SECOND: begin
					second_q <= data_byte;
					pos_q    <= POS_THIRD;
				end
				default: begin
					pos_q <= POS_FIRST;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/ps2_mouse_packet_event_queue.sv
// ps2 mouse packet decoder with per-slot event queues
//
// input channel (in_valid/in_ready): opcode 0 carries a controller status and
// data byte; bytes without output-full and aux status are dropped. three bytes
// make a packet, which is pushed to the queue of its slot (slot out of range
// goes to slot 0, a full queue drops it). a controller word gives no result
// and the next word is taken in the following cycle.
// opcode 1 is a read request: it pops up to pop_limit events from one slot,
// one output word each, last set on the final one. an empty read (empty
// queue, zero count or slot out of range) gives one word with has_event low.
// a read occupies the block from its accept until its last pop (or its empty
// word) has issued; events leave the queue memory at one per cycle while the
// receiver does not stall, set by its single registered read port. the first
// result word passes the memory read stage and then the output register.
// output channel (out_valid/out_ready): a memory read stage and an output
// register; when the receiver stalls, reads stop and both stages hold.
// the block takes new words again as soon as the last pop has issued.
// reset clears the packet assembler and all queue pointers (all queues
// empty); the event memory itself is not cleared.

`default_nettype none
`include "assert_macros.svh"

module ps2_mouse_packet_event_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [7:0]  status_byte,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  slot,
	input  wire logic [5:0]  pop_limit,
	// result side
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             has_event,
	output logic [2:0]       buttons,
	output logic signed [7:0] dx,
	output logic signed [7:0] dy,
	output logic             last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	logic [1:0] state_q;

	// queue pointers, one pair per slot
	logic [ps2mq_pkg::PTR_W-1:0] wptr_q [ps2mq_pkg::SLOT_COUNT];
	logic [ps2mq_pkg::PTR_W-1:0] rptr_q [ps2mq_pkg::SLOT_COUNT];

	// event memory
	logic [ps2mq_pkg::EV_W-1:0] store_mem [ps2mq_pkg::MEM_DEPTH];

	logic                         accept;
	logic                         slot_ok;
	logic [ps2mq_pkg::SLOT_W-1:0] sel_slot;
	logic [ps2mq_pkg::SLOT_W-1:0] rd_slot_q;
	logic [ps2mq_pkg::SLOT_W-1:0] ptr_idx;
	logic [ps2mq_pkg::PTR_W-1:0]  cur_wp;
	logic [ps2mq_pkg::PTR_W-1:0]  cur_rp;
	logic [ps2mq_pkg::PTR_W-1:0]  nxt_wp;
	logic [ps2mq_pkg::PTR_W-1:0]  nxt_rp;
	logic [5:0]                   rem_q;
	ps2mq_pkg::ev_t               ev;
	logic                         push;
	logic                         read_empty;

	// read pipeline
	logic                         v_s1;
	logic                         has_s1;
	logic                         last_s1;
	logic [ps2mq_pkg::EV_W-1:0]   rd_data_s1;
	logic                         s1_move;
	logic                         s1_free;
	logic                         issue_pop;
	logic                         issue_empty;
	logic                         pop_done;

	logic                         out_valid_q;
	logic                         has_event_q;
	logic [2:0]                   buttons_q;
	logic signed [7:0]            dx_q;
	logic signed [7:0]            dy_q;
	logic                         last_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// out of range slots fold to slot 0 for pushes; reads of them pop nothing
	assign slot_ok  = (slot < 8'(ps2mq_pkg::SLOT_COUNT));
	assign sel_slot = slot_ok ? slot[ps2mq_pkg::SLOT_W-1:0] : '0;

	// one pointer read place: the incoming slot when idle, the read slot otherwise
	assign ptr_idx = (state_q == ST_IDLE) ? sel_slot : rd_slot_q;
	assign cur_wp  = wptr_q[ptr_idx];
	assign cur_rp  = rptr_q[ptr_idx];
	assign nxt_wp  = ps2mq_pkg::next_ptr(cur_wp);
	assign nxt_rp  = ps2mq_pkg::next_ptr(cur_rp);

	ps2mq_assembler u_asm (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (accept && (opcode == OP_BYTE)),
		.status_byte (status_byte),
		.data_byte   (data_byte),
		.ev          (ev)
	);

	// one entry stays free so a full queue differs from an empty one
	assign push       = ev.valid && (nxt_wp != cur_rp);
	assign read_empty = !slot_ok || (pop_limit == '0) || (cur_rp == cur_wp);

	assign s1_move     = v_s1 && (!out_valid_q || out_ready);
	assign s1_free     = !v_s1 || s1_move;
	assign issue_pop   = (state_q == ST_READ) && s1_free;
	assign issue_empty = (state_q == ST_EMPTY) && s1_free;
	assign pop_done    = (rem_q == 6'd1) || (nxt_rp == cur_wp);

	// event memory: write on push, registered read on pop
	always_ff @(posedge clk) begin
		if (push) begin
			store_mem[ps2mq_pkg::mem_addr(sel_slot, cur_wp)] <= {ev.buttons, ev.dx, ev.dy};
		end
		if (issue_pop) begin
			rd_data_s1 <= store_mem[ps2mq_pkg::mem_addr(rd_slot_q, cur_rp)];
		end
	end

	// sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_slot_q <= '0;
			rem_q     <= '0;
			for (int i = 0; i < ps2mq_pkg::SLOT_COUNT; i++) begin
				wptr_q[i] <= '0;
				rptr_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_READ) begin
							rd_slot_q <= sel_slot;
							rem_q     <= pop_limit;
							state_q   <= read_empty ? ST_EMPTY : ST_READ;
						end else if (push) begin
							wptr_q[sel_slot] <= nxt_wp;
						end
					end
				end
				ST_READ: begin
					if (issue_pop) begin
						rptr_q[rd_slot_q] <= nxt_rp;
						rem_q             <= rem_q - 6'd1;
						if (pop_done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMPTY: begin
					if (issue_empty) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// memory read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			has_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else if (issue_pop || issue_empty) begin
			v_s1    <= 1'b1;
			has_s1  <= issue_pop;
			last_s1 <= issue_empty || pop_done;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			has_event_q <= has_s1;
			last_q      <= last_s1;
			buttons_q   <= has_s1 ? rd_data_s1[ps2mq_pkg::EV_W-1 -: 3] : 3'd0;
			dx_q        <= has_s1 ? rd_data_s1[15:8] : 8'sd0;
			dy_q        <= has_s1 ? rd_data_s1[7:0] : 8'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign has_event = has_event_q;
	assign buttons   = buttons_q;
	assign dx        = dx_q;
	assign dy        = dy_q;
	assign last      = last_q;

	// a pop only issues on a queue that holds an event and with count left
	`PS2MQ_ASSERT(a_pop_nonempty, (state_q == ST_READ) |-> (cur_rp != cur_wp))
	`PS2MQ_ASSERT(a_pop_count, (state_q == ST_READ) |-> (rem_q != 6'd0))
	// the final pop of a request hands the block back
	`PS2MQ_ASSERT(a_last_idle, (issue_pop && pop_done) |=> (state_q == ST_IDLE))
	// a stalled read stage keeps its word
	`PS2MQ_ASSERT(a_s1_hold, (v_s1 && !s1_move) |=> (v_s1 && $stable(last_s1) && $stable(has_s1)))

endmodule

`default_nettype wire

>>> dv/ps2_mouse_packet_event_queue_tb.sv
`default_nettype none

module ps2_mouse_packet_event_queue_tb;

	// word kinds on the request side
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int HOLD_CYCLES   = 400;
	// no handshake on either side for this long means the block is stuck;
	// well above the long receiver hold-off and any random stall run
	localparam int STUCK_LIMIT   = 3000;
	localparam int TAIL_CYCLES   = 12;
	localparam int MAX_REPORTED  = 10;
	localparam int DIR_ROWS      = 25;
	localparam int FILL_SLOT     = 2;

	// one request word, one field per port
	typedef struct packed {
		logic       op;
		logic [7:0] status;
		logic [7:0] data;
		logic [7:0] slot;
		logic [5:0] pop_limit;
	} request_t;

	// one result word
	typedef struct packed {
		logic                              has_event;
		logic [ps2mq_pkg::BTN_W-1:0]       buttons;
		logic signed [7:0]                 dx;
		logic signed [7:0]                 dy;
		logic                              last;
	} report_t;

	// directed row: typed rows carry their single result word
	typedef struct packed {
		request_t req;
		logic     typed;
		report_t  want;
	} dir_row_t;

	// packet assembler position
	typedef enum logic [1:0] {
		WANT_FIRST,
		WANT_SECOND,
		WANT_THIRD
	} asm_pos_t;

	localparam report_t EMPTY_READ = '{1'b0, 3'd0, 8'h00, 8'h00, 1'b1};
	localparam report_t NO_REPORT  = '0;

	// walked in order from reset; typed results can be read straight off the rows
	localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
		// reads straight after reset: every queue empty
		'{'{OP_READ, 8'h00, 8'h00, 8'd0,   6'd1},  1'b1, EMPTY_READ},
		'{'{OP_READ, 8'hff, 8'hff, 8'd255, 6'd63}, 1'b1, EMPTY_READ},
		'{'{OP_READ, 8'h00, 8'h00, 8'd3,   6'd0},  1'b1, EMPTY_READ},
		// dropped bytes: no status bits, only full, only aux, first byte without sync
		'{'{OP_BYTE, 8'h00, 8'hff, 8'd0,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'h01, 8'h08, 8'd0,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'h20, 8'h08, 8'd0,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'hff, 8'h00, 8'd0,   6'd0},  1'b0, NO_REPORT},
		// packet with all buttons, dx max, dy min, slot out of range goes to slot 0
		'{'{OP_BYTE, 8'h21, 8'h0f, 8'd0,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'h21, 8'h7f, 8'd0,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'h21, 8'h80, 8'd200, 6'd0},  1'b0, NO_REPORT},
		'{'{OP_READ, 8'h00, 8'h00, 8'd0,   6'd63}, 1'b1, '{1'b1, 3'd7, 8'h7f, 8'h80, 1'b1}},
		// packet to the top slot: no buttons, dx min, dy max
		'{'{OP_BYTE, 8'hff, 8'hf8, 8'd5,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'hff, 8'h80, 8'd5,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'hff, 8'h7f, 8'd5,   6'd0},  1'b0, NO_REPORT},
		// slot just past the end is remapped for an event
		'{'{OP_BYTE, 8'h21, 8'h09, 8'd6,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'h21, 8'h01, 8'd6,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'h21, 8'hff, 8'd6,   6'd0},  1'b0, NO_REPORT},
		// second event in the top slot
		'{'{OP_BYTE, 8'h21, 8'h0a, 8'd5,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'h21, 8'h00, 8'd5,   6'd0},  1'b0, NO_REPORT},
		'{'{OP_BYTE, 8'h21, 8'h00, 8'd5,   6'd0},  1'b0, NO_REPORT},
		// read one of two, then the rest
		'{'{OP_READ, 8'h00, 8'h00, 8'd5,   6'd1},  1'b1, '{1'b1, 3'd0, 8'h80, 8'h7f, 1'b1}},
		'{'{OP_READ, 8'h00, 8'h00, 8'd5,   6'd63}, 1'b0, NO_REPORT},
		'{'{OP_READ, 8'h00, 8'h00, 8'd0,   6'd63}, 1'b1, '{1'b1, 3'd1, 8'h01, 8'hff, 1'b1}},
		// a read is not remapped, and a drained queue answers empty
		'{'{OP_READ, 8'h00, 8'h00, 8'd6,   6'd5},  1'b1, EMPTY_READ},
		'{'{OP_READ, 8'h00, 8'h00, 8'd5,   6'd63}, 1'b1, EMPTY_READ}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              opcode = OP_BYTE;
	logic [7:0]        status_byte = '0;
	logic [7:0]        data_byte = '0;
	logic [7:0]        slot = '0;
	logic [5:0]        pop_limit = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              has_event;
	logic [2:0]        buttons;
	logic signed [7:0] dx;
	logic signed [7:0] dy;
	logic              last;

	ps2_mouse_packet_event_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.status_byte (status_byte),
		.data_byte   (data_byte),
		.slot        (slot),
		.pop_limit   (pop_limit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.has_event   (has_event),
		.buttons     (buttons),
		.dx          (dx),
		.dy          (dy),
		.last        (last)
	);

	always #CLK_HALF clk = ~clk;

	// own copy of the block state
	asm_pos_t                    asm_pos = WANT_FIRST;
	logic [7:0]                  asm_first = '0;
	logic [7:0]                  asm_second = '0;
	logic [ps2mq_pkg::EV_W-1:0]  event_mem [ps2mq_pkg::SLOT_COUNT][ps2mq_pkg::QUEUE_DEPTH];
	int unsigned                 queue_head [ps2mq_pkg::SLOT_COUNT];
	int unsigned                 queue_tail [ps2mq_pkg::SLOT_COUNT];

	report_t           pending_reports [$];
	int                mismatch_count = 0;
	int                words_sent = 0;
	int                stuck_cycles = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	logic              recv_held = 1'b0;
	event              hold_go;

	initial begin
		for (int s = 0; s < ps2mq_pkg::SLOT_COUNT; s++) begin
			queue_head[s] = 0;
			queue_tail[s] = 0;
		end
	end

	// advance the state copy by one accepted word; with keep set, queue up its results
	task automatic apply_word(input request_t rq, input bit keep);
		int unsigned tgt;
		int unsigned nxt;
		int unsigned avail;
		int unsigned take;
		logic [ps2mq_pkg::EV_W-1:0] ev;
		report_t rep;
		if (rq.op == OP_BYTE) begin
			// bytes without both status bits leave everything as it was
			if (rq.status[ps2mq_pkg::STATUS_FULL_BIT] && rq.status[ps2mq_pkg::STATUS_AUX_BIT]) begin
				case (asm_pos)
				WANT_FIRST: begin
					// out of sync: a first byte needs the sync bit
					if (rq.data[ps2mq_pkg::SYNC_BIT]) begin
						asm_first = rq.data;
						asm_pos = WANT_SECOND;
					end
				end
				WANT_SECOND: begin
					asm_second = rq.data;
					asm_pos = WANT_THIRD;
				end
				default: begin
					asm_pos = WANT_FIRST;
					tgt = (rq.slot < ps2mq_pkg::SLOT_COUNT) ? rq.slot : 0;
					nxt = (queue_tail[tgt] + 1) % ps2mq_pkg::QUEUE_DEPTH;
					// full queue keeps one entry free and drops the event
					if (nxt != queue_head[tgt]) begin
						event_mem[tgt][queue_tail[tgt]] =
							{asm_first[ps2mq_pkg::BTN_W-1:0], asm_second, rq.data};
						queue_tail[tgt] = nxt;
					end
				end
				endcase
			end
		end else begin
			take = 0;
			if (rq.slot < ps2mq_pkg::SLOT_COUNT) begin
				tgt = rq.slot;
				avail = (queue_tail[tgt] + ps2mq_pkg::QUEUE_DEPTH - queue_head[tgt])
					% ps2mq_pkg::QUEUE_DEPTH;
				take = (avail < rq.pop_limit) ? avail : rq.pop_limit;
				for (int n = 0; n < take; n++) begin
					ev = event_mem[tgt][queue_head[tgt]];
					queue_head[tgt] = (queue_head[tgt] + 1) % ps2mq_pkg::QUEUE_DEPTH;
					rep.has_event = 1'b1;
					rep.buttons = ev[ps2mq_pkg::EV_W-1:16];
					rep.dx = ev[15:8];
					rep.dy = ev[7:0];
					rep.last = (n == take - 1);
					if (keep)
						pending_reports.push_back(rep);
				end
			end
			// empty queue, zero count or slot out of range
			if (take == 0 && keep)
				pending_reports.push_back(EMPTY_READ);
		end
	endtask

	// offer one word, hold it until taken, then account for it
	task automatic send_word(input request_t rq, input bit keep);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= rq.op;
		status_byte <= rq.status;
		data_byte   <= rq.data;
		slot        <= rq.slot;
		pop_limit   <= rq.pop_limit;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_word(rq, keep);
		words_sent++;
	endtask

	function automatic logic [7:0] good_status();
		logic [7:0] st;
		st = 8'($urandom_range(0, 255));
		st[ps2mq_pkg::STATUS_FULL_BIT] = 1'b1;
		st[ps2mq_pkg::STATUS_AUX_BIT] = 1'b1;
		return st;
	endfunction

	// well-formed three-byte packet; only the third byte's slot counts
	task automatic send_packet(input logic [7:0] tgt);
		request_t rq;
		rq = '0;
		rq.op = OP_BYTE;
		for (int b = 0; b < 3; b++) begin
			rq.status = good_status();
			rq.data = 8'($urandom_range(0, 255));
			if (b == 0)
				rq.data[ps2mq_pkg::SYNC_BIT] = 1'b1;
			rq.slot = (b == 2) ? tgt : 8'($urandom_range(0, 255));
			rq.pop_limit = 6'($urandom_range(0, 63));
			send_word(rq, 1'b1);
		end
	endtask

	function automatic logic [7:0] pick_slot();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, ps2mq_pkg::SLOT_COUNT - 1));
	endfunction

	// mostly well-formed packets and reads, some broken packets and noise
	task automatic run_traffic(input int n_words, input int snd_pct, input int rcv_pct);
		int start;
		int pick;
		request_t rq;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		start = words_sent;
		while (words_sent - start < n_words) begin
			pick = $urandom_range(0, 99);
			rq = '0;
			rq.status = 8'($urandom_range(0, 255));
			rq.data = 8'($urandom_range(0, 255));
			rq.slot = pick_slot();
			rq.pop_limit = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 8)) :
				6'($urandom_range(0, 63));
			if (pick < 55) begin
				send_packet(pick_slot());
			end else if (pick < 65) begin
				// truncated packet: a good first byte and maybe one more
				rq.op = OP_BYTE;
				rq.status = good_status();
				rq.data[ps2mq_pkg::SYNC_BIT] = 1'b1;
				send_word(rq, 1'b1);
				if (pick < 60) begin
					rq.status = good_status();
					rq.data = 8'($urandom_range(0, 255));
					send_word(rq, 1'b1);
				end
			end else if (pick < 75) begin
				rq.op = OP_BYTE;
				send_word(rq, 1'b1);
			end else begin
				rq.op = OP_READ;
				send_word(rq, 1'b1);
			end
		end
	endtask

	// receiver hold-off, counted here
	always begin
		@(hold_go);
		recv_held = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_held = 1'b0;
	end

	// result side: check each word taken, then decide readiness for the next cycle
	always @(posedge clk) begin : result_check
		report_t got;
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{has_event, buttons, dx, dy, last};
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTED)
					$display("unexpected result word: has=%0b btn=%0d dx=%0d dy=%0d last=%0b",
						got.has_event, got.buttons, got.dx, got.dy, got.last);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTED)
						$display({"result mismatch: exp has=%0b btn=%0d dx=%0d dy=%0d last=%0b",
							" got has=%0b btn=%0d dx=%0d dy=%0d last=%0b"},
							want.has_event, want.buttons, want.dx, want.dy, want.last,
							got.has_event, got.buttons, got.dx, got.dy, got.last);
				end
			end
		end
		out_ready <= !recv_held && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		request_t rq;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under sender 28, receiver 73 idling
		send_idle_pct = 28;
		recv_idle_pct = 73;
		for (int r = 0; r < DIR_ROWS; r++) begin
			send_word(DIRECTED_ROWS[r].req, !DIRECTED_ROWS[r].typed);
			if (DIRECTED_ROWS[r].typed)
				pending_reports.push_back(DIRECTED_ROWS[r].want);
		end

		// fill one queue past full while the receiver is held off, then read it out;
		// the reads back up behind the stalled output and block the request side
		send_idle_pct = 0;
		->hold_go;
		for (int p = 0; p < ps2mq_pkg::QUEUE_DEPTH; p++)
			send_packet(8'(FILL_SLOT));
		rq = '0;
		rq.op = OP_READ;
		rq.slot = 8'(FILL_SLOT);
		rq.pop_limit = 6'd63;
		send_word(rq, 1'b1);
		send_word(rq, 1'b1);
		for (int s = 0; s < ps2mq_pkg::SLOT_COUNT; s++) begin
			rq.slot = 8'(s);
			send_word(rq, 1'b1);
		end

		// random part: three idling phases
		run_traffic(95, 28, 73);
		run_traffic(95, 73, 28);
		run_traffic(95, 0, 0);
		in_valid <= 1'b0;

		// wait for the last result word, then a little more for strays
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
